// ===== src/matched_line_extent_extractor_top_macros.svh =====
// Assertion helpers for the line extent extractor.
`ifndef MATCHED_LINE_EXTENT_EXTRACTOR_TOP_MACROS_SVH
`define MATCHED_LINE_EXTENT_EXTRACTOR_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MLEE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mlee: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define MLEE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mlee: next-cycle check failed");

`endif

// ===== src/mlee_pkg.sv =====
package mlee_pkg;

  localparam int LINE_W = 32;
  localparam int OUT_W  = 32;

  localparam logic [7:0] BYTE_LF       = 8'h0A;
  localparam logic [7:0] BYTE_CR       = 8'h0D;
  localparam logic [7:0] BYTE_NEL_LAST = 8'h85;
  localparam logic [7:0] BYTE_NUL      = 8'h00;

  // queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== src/matched_line_extent_extractor_top.sv =====
// Matched line extent extractor.
// Input channel (in_*): one text byte position per item, with the next byte,
//   a line-break flag, a match flag and a last-position flag.
// Result channel (out_*): one item per matched break: line number, first and
//   last byte position to output, an empty flag and a newline request.
// cfg_wr_en/cfg_wr_data write normalize_breaks; write only while idle.
// Throughput: one input item per cycle while in_stall is low. The front
//   updates line state per item; the only loop is that state update.
// Path: an accepted item's record is written to the queue, then popped
//   into the output register, where out_valid shows it once the output
//   side is free.
// A two-entry queue sits between front and back; in_stall rises only when
//   it is full, so the input keeps flowing while a result waits.
// When out_stall is high the result holds; the queue fills, then in_stall.
// Reset (rst_n low, synchronous): position 0, line 1, queue and output
//   empty, normalize_breaks 0. No clearing pass.
// An item with is_final set is processed, then line state returns to reset.
`include "matched_line_extent_extractor_top_macros.svh"

module matched_line_extent_extractor_top #(
  parameter int POS_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_text_byte,
  input  logic [7:0]                  in_following_byte,
  input  logic                        in_is_break,
  input  logic                        in_is_match,
  input  logic                        in_is_final,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mlee_pkg::LINE_W-1:0] out_line_number,
  output logic [mlee_pkg::OUT_W-1:0]  out_start_pos,
  output logic [mlee_pkg::OUT_W-1:0]  out_end_pos,
  output logic                        out_is_empty,
  output logic                        out_add_newline
);

  // record: {normalize, line number, start, end}
  localparam int REC_W = 1 + mlee_pkg::LINE_W + 2 * POS_WIDTH;

  logic              accept;
  logic              push, pop;
  logic [REC_W-1:0]  push_data, q_data;
  mlee_pkg::q_stat_t q_stat;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  // front: line tracking and extent bounds
  mlee_front #(
    .POS_WIDTH(POS_WIDTH),
    .REC_W    (REC_W)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .accept        (accept),
    .text_byte     (in_text_byte),
    .following_byte(in_following_byte),
    .is_break      (in_is_break),
    .is_match      (in_is_match),
    .is_final      (in_is_final),
    .push          (push),
    .push_data     (push_data)
  );

  mlee_fifo #(
    .W(REC_W)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .pop_data (q_data),
    .stat     (q_stat)
  );

  // back: length, last byte, empty flag, output register
  mlee_back #(
    .POS_WIDTH(POS_WIDTH),
    .REC_W    (REC_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .q_data         (q_data),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_line_number(out_line_number),
    .out_start_pos  (out_start_pos),
    .out_end_pos    (out_end_pos),
    .out_is_empty   (out_is_empty),
    .out_add_newline(out_add_newline)
  );

  // a queued record with a free output reaches the output next cycle
  `MLEE_ASSERT_NEXT(a_drain, (!q_stat.empty && !out_stall), out_valid)
  // a pushed record is in the queue next cycle
  `MLEE_ASSERT_NEXT(a_push_held, push, !q_stat.empty)
  // only an accepted matched break queues a record
  `MLEE_ASSERT_NOW(a_push_src, push, (accept && in_is_break && in_is_match))

endmodule

// ===== src/mlee_front.sv =====
module mlee_front #(
  parameter int POS_WIDTH = 32,
  parameter int REC_W     = 1 + mlee_pkg::LINE_W + 2 * POS_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic                 accept,
  input  logic [7:0]           text_byte,
  input  logic [7:0]           following_byte,
  input  logic                 is_break,
  input  logic                 is_match,
  input  logic                 is_final,
  output logic                 push,
  output logic [REC_W-1:0]     push_data
);

  localparam logic [POS_WIDTH-1:0] ONE = POS_WIDTH'(1);
  localparam logic [POS_WIDTH-1:0] TWO = POS_WIDTH'(2);

  logic                        norm_r;
  logic [POS_WIDTH-1:0]        position_r, position_nxt;
  logic [POS_WIDTH-1:0]        cur_start_r, cur_start_nxt;
  logic [mlee_pkg::LINE_W-1:0] line_count_r, line_count_nxt;
  logic                        start_lf_r, start_lf_nxt;
  logic                        start_pend_r, start_pend_nxt;
  logic [7:0]                  prev_byte_r;

  logic                 pend1, lf1, lf_start;
  logic [POS_WIDTH-1:0] pos_p1, pos_m1, ext_start, ext_end, new_start;

  always_comb begin
    pend1  = start_pend_r;
    lf1    = start_lf_r;
    pos_p1 = position_r + ONE;
    pos_m1 = position_r - ONE;
    // first byte of the line arrives now
    if (start_pend_r && (position_r == cur_start_r)) begin
      lf1   = (text_byte == mlee_pkg::BYTE_LF);
      pend1 = 1'b0;
    end
    if (pend1) begin
      lf_start = (cur_start_r == pos_p1) && (following_byte == mlee_pkg::BYTE_LF);
    end else begin
      lf_start = lf1;
    end
    ext_start = (lf_start && (cur_start_r != position_r)) ? cur_start_r + ONE : cur_start_r;

    ext_end = position_r;
    if (norm_r) begin
      if (text_byte == mlee_pkg::BYTE_NEL_LAST) begin
        ext_end = pos_m1;
      end else if (text_byte > mlee_pkg::BYTE_CR) begin
        ext_end = position_r - TWO;
      end
    end else begin
      if (text_byte == mlee_pkg::BYTE_NUL) begin
        ext_end = pos_m1;
      end else if ((text_byte == mlee_pkg::BYTE_CR) &&
                   (following_byte == mlee_pkg::BYTE_LF)) begin
        ext_end = pos_p1;
      end
    end

    new_start = is_match ? ext_end + ONE : pos_p1;

    position_nxt   = pos_p1;
    cur_start_nxt  = cur_start_r;
    line_count_nxt = line_count_r;
    start_lf_nxt   = lf1;
    start_pend_nxt = pend1;
    if (is_break) begin
      cur_start_nxt  = new_start;
      line_count_nxt = line_count_r + mlee_pkg::LINE_W'(1);
      if (new_start == pos_m1) begin
        start_lf_nxt   = (prev_byte_r == mlee_pkg::BYTE_LF);
        start_pend_nxt = 1'b0;
      end else if (new_start == position_r) begin
        start_lf_nxt   = (text_byte == mlee_pkg::BYTE_LF);
        start_pend_nxt = 1'b0;
      end else begin
        start_lf_nxt   = 1'b0;
        start_pend_nxt = 1'b1;
      end
    end
    if (is_final) begin
      position_nxt   = '0;
      cur_start_nxt  = '0;
      line_count_nxt = mlee_pkg::LINE_W'(1);
      start_lf_nxt   = 1'b0;
      start_pend_nxt = 1'b1;
    end
  end

  assign push      = accept && is_break && is_match;
  assign push_data = {norm_r, line_count_r, ext_start, ext_end};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_r       <= 1'b0;
      position_r   <= '0;
      cur_start_r  <= '0;
      line_count_r <= mlee_pkg::LINE_W'(1);
      start_lf_r   <= 1'b0;
      start_pend_r <= 1'b1;
      prev_byte_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        norm_r <= cfg_wr_data;
      end
      if (accept) begin
        position_r   <= position_nxt;
        cur_start_r  <= cur_start_nxt;
        line_count_r <= line_count_nxt;
        start_lf_r   <= start_lf_nxt;
        start_pend_r <= start_pend_nxt;
        prev_byte_r  <= is_final ? 8'h00 : text_byte;
      end
    end
  end

endmodule

// ===== src/mlee_fifo.sv =====
module mlee_fifo #(
  parameter int W = 97
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [W-1:0]       push_data,
  input  logic               pop,
  output logic [W-1:0]       pop_data,
  output mlee_pkg::q_stat_t  stat
);

  logic [W-1:0]                mem [mlee_pkg::QDEPTH];
  logic [mlee_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [mlee_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + mlee_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - mlee_pkg::QCNT_W'(1);
    end
  end

  assign pop_data   = mem[rd_ptr_r];
  assign stat.full  = (cnt_r == mlee_pkg::QCNT_W'(mlee_pkg::QDEPTH));
  assign stat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + mlee_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + mlee_pkg::QPTR_W'(1);
      end
    end
  end

endmodule

// ===== src/mlee_back.sv =====
module mlee_back #(
  parameter int POS_WIDTH = 32,
  parameter int REC_W     = 1 + mlee_pkg::LINE_W + 2 * POS_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mlee_pkg::q_stat_t           q_stat,
  input  logic [REC_W-1:0]            q_data,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mlee_pkg::LINE_W-1:0] out_line_number,
  output logic [mlee_pkg::OUT_W-1:0]  out_start_pos,
  output logic [mlee_pkg::OUT_W-1:0]  out_end_pos,
  output logic                        out_is_empty,
  output logic                        out_add_newline
);

  logic                        rec_norm;
  logic [mlee_pkg::LINE_W-1:0] rec_line;
  logic [POS_WIDTH-1:0]        rec_start, rec_end, len, last;
  logic                        valid_r;

  assign {rec_norm, rec_line, rec_start, rec_end} = q_data;

  always_comb begin
    if (rec_norm) begin
      len  = rec_end - rec_start;
      last = rec_end - POS_WIDTH'(1);
    end else begin
      len  = rec_end - rec_start + POS_WIDTH'(1);
      last = rec_end;
    end
  end

  assign pop       = !q_stat.empty && (!valid_r || !out_stall);
  assign out_valid = valid_r;

  always_ff @(posedge clk) begin
    if (pop) begin
      out_line_number <= rec_line;
      out_start_pos   <= mlee_pkg::OUT_W'(rec_start);
      out_end_pos     <= mlee_pkg::OUT_W'(last);
      out_is_empty    <= (len == '0) || len[POS_WIDTH-1];
      out_add_newline <= rec_norm;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

endmodule
